FILE: rtl/dss_pkg.sv
// Shared constants and types for the delimiter split stream block.
`default_nettype none
package dss_pkg;

   // Window geometry
   localparam int DELIM_MAX = 8;
   localparam int LEN_CAP   = (DELIM_MAX < 8) ? DELIM_MAX : 8;
   localparam int CNT_W     = $clog2(DELIM_MAX + 1);
   localparam int DROP_W    = (DELIM_MAX > 1) ? $clog2(DELIM_MAX) : 1;

   // Field and register widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 4;
   localparam int DATA_W = 64;

   // Register indexes
   localparam logic CSR_IDX_LEN   = 1'b0;
   localparam logic CSR_IDX_BYTES = 1'b1;

   // Register reset values
   localparam logic [LEN_W-1:0]  LEN_RESET   = 4'd1;
   localparam logic [DATA_W-1:0] BYTES_RESET = 64'd44;

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

   // Per-cell control: take the appended byte, shift toward cell 0
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage
`default_nettype wire

FILE: rtl/dss_cell.sv
// One window cell: holds a byte, compares it with its delimiter byte, shifts left.
`default_nettype none
module dss_cell (
   input  wire logic                         clock,
   input  wire dss_pkg::cell_ctrl_type       ctrl,
   input  wire logic [dss_pkg::BYTE_W-1:0]   app_byte,
   input  wire logic [dss_pkg::BYTE_W-1:0]   right_byte,
   input  wire logic [dss_pkg::BYTE_W-1:0]   delim_byte,
   output logic      [dss_pkg::BYTE_W-1:0]   cur_byte,
   output logic                              hit
);

   logic [dss_pkg::BYTE_W-1:0] byte_ff;
   logic [dss_pkg::BYTE_W-1:0] byte_in;

   // Byte as seen this cycle, with an incoming append folded in
   assign cur_byte = ctrl.load ? app_byte : byte_ff;
   assign hit      = (cur_byte == delim_byte);
   assign byte_in  = ctrl.shift ? right_byte : cur_byte;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule
`default_nettype wire

FILE: rtl/delimiter_split_stream.sv
// Throughput: one byte per cycle while the output is free; a match ending the
// window owes its newline, sent as the next byte is taken into the append phase.
// After a last beat the window drains one byte per cycle while the output is
// free, then the closing newline. A shorter delimiter length re-scans the held
// window one step per cycle while the output is free, then drops each match.
// Reset is synchronous: window empty, no newline owed, delim_len 1, delim_bytes 44.
`default_nettype none
module delimiter_split_stream (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Configuration
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [dss_pkg::DATA_W-1:0]    csr_wdata,
   // Input beats
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [dss_pkg::BYTE_W-1:0]    req_in_byte,
   input  wire logic                          req_in_last,
   // Result beats
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [dss_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                               rsp_out_last
);

   localparam int CW = dss_pkg::CNT_W;
   localparam int DW = dss_pkg::DROP_W;
   localparam int NC = dss_pkg::DELIM_MAX;

   // Sequencer codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_APPEND = 3'd1;
   localparam logic [2:0] PH_SCAN   = 3'd2;
   localparam logic [2:0] PH_DROP   = 3'd3;
   localparam logic [2:0] PH_FLUSH  = 3'd4;
   localparam logic [2:0] PH_CLOSE  = 3'd5;

   // Registers
   logic [dss_pkg::LEN_W-1:0]  csr_len_ff,   csr_len_in;
   logic [dss_pkg::DATA_W-1:0] csr_bytes_ff, csr_bytes_in;
   logic [2:0]                 phase_ff,     phase_in;
   logic [CW-1:0]              count_ff,     count_in;
   logic                       owed_ff,      owed_in;
   logic                       last_ff,      last_in;
   logic [dss_pkg::BYTE_W-1:0] hold_ff,      hold_in;
   logic [DW-1:0]              drop_ff,      drop_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dss_pkg::BYTE_W-1:0] rsp_byte_ff,  rsp_byte_in;
   logic                       rsp_last_ff,  rsp_last_in;

   // Datapath signals
   logic [dss_pkg::LEN_W-1:0]  len_sat;
   logic [CW-1:0]              eff_len;
   logic                       out_free;
   logic                       req_accept;
   logic                       app;
   logic                       scan_go;
   logic                       item_last;
   logic [dss_pkg::BYTE_W-1:0] app_byte;
   logic [CW-1:0]              vcount;
   logic                       win_match;
   logic                       shift;
   logic                       emit;
   logic [dss_pkg::BYTE_W-1:0] emit_byte;
   logic                       emit_last;

   dss_pkg::cell_ctrl_type     cell_ctrl [NC];
   logic [dss_pkg::BYTE_W-1:0] vbyte     [NC];
   logic [NC-1:0]              hit;

   // Phase after the window has been updated to c bytes
   function automatic logic [2:0] next_phase(input logic [CW-1:0] c,
                                             input logic          lst,
                                             input logic [CW-1:0] len);
      logic [2:0] ph;
      if (c >= len) begin
         ph = PH_SCAN;
      end else if (lst) begin
         ph = (c != '0) ? PH_FLUSH : PH_CLOSE;
      end else begin
         ph = PH_IDLE;
      end
      return ph;
   endfunction

   // Effective delimiter length: zero reads as one, saturate at the cap
   always_comb begin
      if (csr_len_ff == '0) begin
         len_sat = dss_pkg::LEN_W'(1);
      end else if (csr_len_ff > dss_pkg::LEN_W'(dss_pkg::LEN_CAP)) begin
         len_sat = dss_pkg::LEN_W'(dss_pkg::LEN_CAP);
      end else begin
         len_sat = csr_len_ff;
      end
   end
   assign eff_len = CW'(len_sat);

   // Config writes
   always_comb begin
      csr_len_in   = csr_len_ff;
      csr_bytes_in = csr_bytes_ff;
      if (csr_we) begin
         unique case (csr_index)
            dss_pkg::CSR_IDX_LEN:   csr_len_in   = csr_wdata[dss_pkg::LEN_W-1:0];
            dss_pkg::CSR_IDX_BYTES: csr_bytes_in = csr_wdata;
            default:                csr_len_in   = csr_len_ff;
         endcase
      end
   end

   // Handshake and step enables
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((phase_ff == PH_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign app        = (req_accept && !owed_ff) || ((phase_ff == PH_APPEND) && out_free);
   assign scan_go    = app || ((phase_ff == PH_SCAN) && out_free);
   assign item_last  = (phase_ff == PH_IDLE) ? req_in_last : last_ff;
   assign app_byte   = (phase_ff == PH_IDLE) ? req_in_byte : hold_ff;
   assign vcount     = count_ff + CW'(app);

   // Row of window cells; cell 0 is the oldest byte
   for (genvar i = 0; i < NC; i++) begin : g_cell
      logic [dss_pkg::BYTE_W-1:0] right_byte;
      logic [dss_pkg::BYTE_W-1:0] delim_byte;

      if (i == NC - 1) begin : g_end
         assign right_byte = '0;
      end else begin : g_mid
         assign right_byte = vbyte[i+1];
      end

      if (i < 8) begin : g_dbyte
         assign delim_byte = csr_bytes_ff[8*i +: 8];
      end else begin : g_nobyte
         assign delim_byte = '0;
      end

      assign cell_ctrl[i].load  = app && (count_ff == CW'(i));
      assign cell_ctrl[i].shift = shift;

      dss_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .app_byte   (app_byte),
         .right_byte (right_byte),
         .delim_byte (delim_byte),
         .cur_byte   (vbyte[i]),
         .hit        (hit[i])
      );
   end

   // Delimiter compare over the first eff_len cells
   always_comb begin
      win_match = 1'b1;
      for (int i = 0; i < NC; i++) begin
         if ((CW'(i) < eff_len) && !hit[i]) begin
            win_match = 1'b0;
         end
      end
   end

   // Sequencer
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      owed_in   = owed_ff;
      last_in   = last_ff;
      hold_in   = hold_ff;
      drop_in   = drop_ff;
      shift     = 1'b0;
      emit      = 1'b0;
      emit_byte = vbyte[0];
      emit_last = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_accept) begin
               last_in = req_in_last;
               // Owed newline goes first; the byte is held and appended in the append phase
               if (owed_ff) begin
                  emit      = 1'b1;
                  emit_byte = dss_pkg::NEWLINE_BYTE;
                  owed_in   = 1'b0;
                  hold_in   = req_in_byte;
                  phase_in  = PH_APPEND;
               end
            end
         end
         PH_APPEND, PH_SCAN: begin
         end
         PH_DROP: begin
            // Rest of a match removed one byte per cycle
            shift    = 1'b1;
            count_in = count_ff - CW'(1);
            drop_in  = drop_ff - DW'(1);
            if (drop_ff == DW'(1)) begin
               phase_in = next_phase(count_ff - CW'(1), item_last, eff_len);
            end
         end
         PH_FLUSH: begin
            if (out_free) begin
               emit     = 1'b1;
               shift    = 1'b1;
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  phase_in = PH_CLOSE;
               end
            end
         end
         PH_CLOSE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = dss_pkg::NEWLINE_BYTE;
               emit_last = 1'b1;
               count_in  = '0;
               owed_in   = 1'b0;
               phase_in  = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // One scan step over the window, appended byte included
      if (scan_go) begin
         if (vcount >= eff_len) begin
            if (win_match) begin
               if (vcount == eff_len) begin
                  count_in = '0;
                  owed_in  = 1'b1;
                  phase_in = next_phase('0, item_last, eff_len);
               end else begin
                  emit      = 1'b1;
                  emit_byte = dss_pkg::NEWLINE_BYTE;
                  shift     = 1'b1;
                  count_in  = vcount - CW'(1);
                  if (eff_len > CW'(1)) begin
                     drop_in  = DW'(eff_len - CW'(1));
                     phase_in = PH_DROP;
                  end else begin
                     phase_in = next_phase(vcount - CW'(1), item_last, eff_len);
                  end
               end
            end else begin
               emit     = 1'b1;
               shift    = 1'b1;
               count_in = vcount - CW'(1);
               phase_in = next_phase(vcount - CW'(1), item_last, eff_len);
            end
         end else begin
            count_in = vcount;
            phase_in = next_phase(vcount, item_last, eff_len);
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      rsp_byte_in  = emit ? emit_byte : rsp_byte_ff;
      rsp_last_in  = emit ? emit_last : rsp_last_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff   <= dss_pkg::LEN_RESET;
         csr_bytes_ff <= dss_pkg::BYTES_RESET;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         owed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_len_ff   <= csr_len_in;
         csr_bytes_ff <= csr_bytes_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         owed_ff      <= owed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      hold_ff     <= hold_in;
      drop_ff     <= drop_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // Window never holds more bytes than it has cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(NC))
      else $error("window count out of range");

   // The closing beat is always a newline
   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_last) |-> (rsp_out_byte == dss_pkg::NEWLINE_BYTE))
      else $error("closing beat is not a newline");

   // Closing newline leaves an empty window with nothing owed
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLOSE && out_free) |=> (count_ff == '0 && !owed_ff
                                               && phase_ff == PH_IDLE))
      else $error("text end did not clear the window");

   // Drop phase always has bytes left to remove
   a_drop_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DROP) |-> (drop_ff != '0 && count_ff != '0))
      else $error("drop phase with nothing to drop");
`endif

endmodule
`default_nettype wire

FILE: bench/split_checker.sv
// Checker for the delimiter split stream: predicts result beats and compares each one.
`timescale 1ns / 1ps
module split_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [dss_pkg::DATA_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [dss_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          req_in_last,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [dss_pkg::BYTE_W-1:0]    rsp_out_byte,
   input  logic                          rsp_out_last,
   output int                            fail_count,
   output int                            pending,
   output int                            beats_out
);

   typedef struct packed {
      logic [dss_pkg::BYTE_W-1:0] out_byte;
      logic                       out_last;
   } split_beat_type;

   // Mirror of the registers and of the lookahead window
   logic [dss_pkg::LEN_W-1:0]  len_reg;
   logic [dss_pkg::DATA_W-1:0] delim_reg;
   logic [dss_pkg::BYTE_W-1:0] lookahead [dss_pkg::DELIM_MAX];
   int unsigned                held;
   bit                         newline_due;
   split_beat_type             expected_q [$];

   // Length in use: zero counts as one, large values saturate
   function automatic int unsigned active_len();
      int unsigned n;
      n = len_reg;
      if (n < 1) n = 1;
      if (n > dss_pkg::LEN_CAP) n = dss_pkg::LEN_CAP;
      return n;
   endfunction

   function automatic void expect_beat(logic [dss_pkg::BYTE_W-1:0] b, logic l);
      split_beat_type e;
      e.out_byte = b;
      e.out_last = l;
      expected_q.push_back(e);
   endfunction

   function automatic void drop_held(int unsigned k);
      for (int unsigned i = 0; i + k < held; i++) lookahead[i] = lookahead[i + k];
      held -= k;
   endfunction

   function automatic bit head_is_delim(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (lookahead[i] != delim_reg[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Greedy scan: a full-length head either matches or releases its first byte
   function automatic void scan_held();
      int unsigned n;
      n = active_len();
      while (held >= n) begin
         if (head_is_delim(n)) begin
            drop_held(n);
            if (held > 0) expect_beat(dss_pkg::NEWLINE_BYTE, 1'b0);
            else newline_due = 1'b1;
         end else begin
            expect_beat(lookahead[0], 1'b0);
            drop_held(1);
         end
      end
   endfunction

   // One text byte in: owed newline, append, scan, and flush on the last byte
   function automatic void split_byte(logic [dss_pkg::BYTE_W-1:0] b, logic l);
      if (newline_due) begin
         expect_beat(dss_pkg::NEWLINE_BYTE, 1'b0);
         newline_due = 1'b0;
      end
      if (held < dss_pkg::DELIM_MAX) begin
         lookahead[held] = b;
         held++;
      end
      scan_held();
      if (l) begin
         for (int unsigned i = 0; i < held; i++) expect_beat(lookahead[i], 1'b0);
         held = 0;
         newline_due = 1'b0;
         expect_beat(dss_pkg::NEWLINE_BYTE, 1'b1);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Sample all three ports at the rising edge
   always @(posedge clock) begin
      split_beat_type want;
      if (reset) begin
         len_reg = dss_pkg::LEN_RESET;
         delim_reg = dss_pkg::BYTES_RESET;
         held = 0;
         newline_due = 1'b0;
         expected_q.delete();
         fail_count = 0;
         beats_out = 0;
      end else begin
         // a new length or delimiter takes effect on the next byte's scan
         if (csr_we) begin
            if (csr_index == dss_pkg::CSR_IDX_LEN) begin
               len_reg = csr_wdata[dss_pkg::LEN_W-1:0];
            end else begin
               delim_reg = csr_wdata;
            end
         end
         if (req_valid && !req_stall) split_byte(req_in_byte, req_in_last);
         if (rsp_valid && !rsp_stall) begin
            beats_out++;
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat byte %h last %b",
                                         rsp_out_byte, rsp_out_last));
            end else begin
               want = expected_q.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_out_last !== want.out_last)
                  report_mismatch($sformatf("out_last %b, expected %b (byte %h)",
                                            rsp_out_last, want.out_last, want.out_byte));
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: bench/testbench.sv
// Top of the delimiter split stream bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

   localparam int HOLD_CYCLES   = 100;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 20000;
   localparam logic [dss_pkg::BYTE_W-1:0] COMMA = 8'h2C;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic                       csr_index;
   logic [dss_pkg::DATA_W-1:0] csr_wdata;
   logic                       req_valid;
   logic                       req_stall;
   logic [dss_pkg::BYTE_W-1:0] req_in_byte;
   logic                       req_in_last;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [dss_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                       rsp_out_last;

   int fail_count;
   int pending;
   int beats_out;

   int unsigned send_idle_pct;
   int unsigned rsp_idle_pct;
   int unsigned beats_sent;
   int unsigned texts_sent;
   int unsigned holds_asked;
   int unsigned holds_done;
   int unsigned hold_left;

   // Register values as written, used to shape texts
   logic [dss_pkg::LEN_W-1:0]  cur_len;
   logic [dss_pkg::DATA_W-1:0] cur_delim;
   bit   [15:0]                lens_written;
   logic [dss_pkg::BYTE_W-1:0] text_q [$];

   delimiter_split_stream DUT (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   split_checker check_split (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .fail_count   (fail_count),
      .pending      (pending),
      .beats_out    (beats_out)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Run limit
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Receiver: random stall, or a long hold-off when one is asked for
   initial begin
      rsp_stall = 1'b0;
      holds_done = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // One input beat; entered and left at a falling edge
   task automatic send_beat(input logic [dss_pkg::BYTE_W-1:0] b, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_in_byte = b;
      req_in_last = l;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
      texts_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [dss_pkg::DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == dss_pkg::CSR_IDX_LEN) begin
         cur_len = value[dss_pkg::LEN_W-1:0];
         lens_written[cur_len] = 1'b1;
      end else begin
         cur_delim = value;
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Stop sending until every expected beat is back, then let the window settle
   task automatic wait_drain();
      int guard;
      req_valid = 1'b0;
      guard = 0;
      while (pending != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int unsigned delim_span();
      if (cur_len == 0) return 1;
      if (cur_len > dss_pkg::LEN_CAP) return dss_pkg::LEN_CAP;
      return cur_len;
   endfunction

   // Half the delimiters come from a tiny alphabet so that partial matches overlap
   function automatic logic [dss_pkg::DATA_W-1:0] pick_delim();
      logic [dss_pkg::DATA_W-1:0] d;
      d = {$urandom, $urandom};
      if ($urandom_range(1) == 0) begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(2))
               0: d[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W] = 8'h00;
               1: d[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W] = 8'hFF;
               default: d[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W] = COMMA;
            endcase
         end
      end
      return d;
   endfunction

   function automatic logic [dss_pkg::BYTE_W-1:0] text_byte();
      int unsigned k;
      k = $urandom_range(7);
      if ($urandom_range(1) == 0) return 8'($urandom_range(255));
      return cur_delim[dss_pkg::BYTE_W*k +: dss_pkg::BYTE_W];
   endfunction

   // Text of segments: plain bytes, whole delimiters, broken delimiter prefixes
   function automatic void build_text(bit noise);
      int unsigned span;
      int unsigned pick;
      int unsigned cut;
      span = delim_span();
      text_q.delete();
      repeat ($urandom_range(1, 8)) begin
         pick = $urandom_range(99);
         if (noise || pick < 40) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(text_byte());
         end else if (pick < 80) begin
            for (int unsigned i = 0; i < span; i++)
               text_q.push_back(cur_delim[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W]);
         end else begin
            cut = $urandom_range(1, span);
            for (int unsigned i = 0; i < cut; i++)
               text_q.push_back(cur_delim[dss_pkg::BYTE_W*i +: dss_pkg::BYTE_W]);
         end
      end
   endfunction

   // New length and delimiter, in random order, with the block drained
   task automatic random_config();
      int unsigned pick;
      logic [dss_pkg::DATA_W-1:0] w;
      wait_drain();
      pick = $urandom_range(99);
      w = {$urandom, $urandom};
      if (pick < 10) w[dss_pkg::LEN_W-1:0] = '0;
      else if (pick < 20) w[dss_pkg::LEN_W-1:0] = dss_pkg::LEN_W'($urandom_range(9, 15));
      else w[dss_pkg::LEN_W-1:0] = dss_pkg::LEN_W'($urandom_range(1, 8));
      if ($urandom_range(1) == 0) begin
         write_reg(dss_pkg::CSR_IDX_LEN, w);
         write_reg(dss_pkg::CSR_IDX_BYTES, pick_delim());
      end else begin
         write_reg(dss_pkg::CSR_IDX_BYTES, pick_delim());
         write_reg(dss_pkg::CSR_IDX_LEN, w);
      end
   endtask

   task automatic random_phase(input int unsigned sidle, input int unsigned ridle,
                               input int unsigned count);
      int unsigned goal;
      send_idle_pct = sidle;
      rsp_idle_pct = ridle;
      goal = beats_sent + count;
      while (beats_sent < goal) begin
         if ($urandom_range(99) < 30) random_config();
         build_text($urandom_range(99) < 20);
         send_text();
      end
   endtask

   // Stimulus
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = dss_pkg::CSR_IDX_LEN;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_in_byte = '0;
      req_in_last = 1'b0;
      cur_len = dss_pkg::LEN_RESET;
      cur_delim = dss_pkg::BYTES_RESET;
      lens_written = '0;
      beats_sent = 0;
      texts_sent = 0;
      holds_asked = 0;
      send_idle_pct = 32;
      rsp_idle_pct = 86;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Reset delimiter: back-to-back matches, byte extremes, match at end of text
      text_q = '{8'h00, COMMA, COMMA, 8'hFF, COMMA};
      send_text();

      // Zero length acts as one; a zero delimiter byte is matched literally
      wait_drain();
      write_reg(dss_pkg::CSR_IDX_LEN, 64'd0);
      write_reg(dss_pkg::CSR_IDX_BYTES, 64'd0);
      text_q = '{8'h00, 8'h41};
      send_text();

      // Three bytes with zeros; a false start overlaps the real match
      wait_drain();
      write_reg(dss_pkg::CSR_IDX_LEN, 64'd3);
      write_reg(dss_pkg::CSR_IDX_BYTES, 64'h0000_0000_0000_AB00);
      text_q = '{8'h00, 8'h00, 8'hAB, 8'h00, 8'h7F};
      send_text();

      // Oversized length saturates to eight; full match, then a short tail
      wait_drain();
      write_reg(dss_pkg::CSR_IDX_LEN, 64'd15);
      write_reg(dss_pkg::CSR_IDX_BYTES, 64'hFEDC_BA98_7654_3210);
      text_q = '{8'h10, 8'h32, 8'h54, 8'h76, 8'h98, 8'hBA, 8'hDC, 8'hFE, 8'h01};
      send_text();

      // Length cut to two while five bytes sit in the window
      text_q = '{8'h10, 8'h32, 8'h54, 8'h10, 8'h32};
      foreach (text_q[i]) send_beat(text_q[i], 1'b0);
      wait_drain();
      write_reg(dss_pkg::CSR_IDX_LEN, 64'd2);
      send_beat(8'h55, 1'b1);
      texts_sent++;

      // Random texts under two idling patterns
      random_phase(32, 86, 30);
      random_phase(86, 32, 30);

      // Long receiver hold-off while a long text keeps coming
      wait_drain();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      holds_asked++;
      text_q.delete();
      repeat (50) text_q.push_back(text_byte());
      send_text();

      random_phase(0, 0, 30);
      wait_drain();

      $display("Split %0d texts (%0d input beats) into %0d result beats,",
               texts_sent, beats_sent, beats_out);
      $display("with the length register set to %0d of its 16 values.",
               $countones(lens_written));
      if (pending != 0) $display("%0d expected result beats never arrived", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/dss_pkg.sv
rtl/dss_cell.sv
rtl/delimiter_split_stream.sv
bench/split_checker.sv
bench/testbench.sv
